// ===== src/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcc_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CLICK_W = 8;
  localparam int unsigned EV_W    = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [CLICK_W-1:0] CLICK_MAX = '1;
  localparam logic [CLICK_W-1:0] CLICKS_TEST   = CLICK_W'(3);
  localparam logic [CLICK_W-1:0] CLICKS_SINGLE = CLICK_W'(1);

  localparam logic [CNT_W-1:0] LONG_PRESS_RST = CNT_W'(150);
  localparam logic [CNT_W-1:0] CLICK_MIN_RST  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CLICK_MAX_RST  = CNT_W'(50);
  localparam logic [CNT_W-1:0] GAP_RST        = CNT_W'(50);
  localparam logic [CNT_W-1:0] ALARM_RST      = CNT_W'(0);

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_LONG_PRESS = 3'd0,
    REG_CLICK_MIN  = 3'd1,
    REG_CLICK_MAX  = 3'd2,
    REG_GAP        = 3'd3,
    REG_ALARM      = 3'd4
  } reg_idx_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 3'd0,
    EV_CONFIG   = 3'd1,
    EV_TEST     = 3'd2,
    EV_SILENCE  = 3'd3,
    EV_SELFTEST = 3'd4
  } event_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] click_min_ticks;
    logic [CNT_W-1:0] click_max_ticks;
    logic [CNT_W-1:0] gap_ticks;
    logic [CNT_W-1:0] alarm_level;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/bcc_cfg_regs.sv =====
// APB-style register file holding the classifier thresholds.
// Depends on bcc_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.click_min_ticks  <= CLICK_MIN_RST;
      cfg_r.click_max_ticks  <= CLICK_MAX_RST;
      cfg_r.gap_ticks        <= GAP_RST;
      cfg_r.alarm_level      <= ALARM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LONG_PRESS: cfg_r.long_press_ticks <= pwdata[CNT_W-1:0];
        REG_CLICK_MIN:  cfg_r.click_min_ticks  <= pwdata[CNT_W-1:0];
        REG_CLICK_MAX:  cfg_r.click_max_ticks  <= pwdata[CNT_W-1:0];
        REG_GAP:        cfg_r.gap_ticks        <= pwdata[CNT_W-1:0];
        REG_ALARM:      cfg_r.alarm_level      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LONG_PRESS: prdata = DATA_W'(cfg_r.long_press_ticks);
      REG_CLICK_MIN:  prdata = DATA_W'(cfg_r.click_min_ticks);
      REG_CLICK_MAX:  prdata = DATA_W'(cfg_r.click_max_ticks);
      REG_GAP:        prdata = DATA_W'(cfg_r.gap_ticks);
      REG_ALARM:      prdata = DATA_W'(cfg_r.alarm_level);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bcc_core.sv =====
// Hold/gap/click counters and the event decision for one sample.
// Depends on bcc_pkg; state advances only when step is high.
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             step,
  input  wire logic             key_level,
  input  wire logic [CNT_W-1:0] gas_level,
  input  wire logic             in_normal_mode,
  output event_t                event_code
);

  logic [CNT_W-1:0]   hold_r, hold_nxt, hold_inc;
  logic [CNT_W-1:0]   gap_r, gap_nxt, gap_inc;
  logic [CLICK_W-1:0] click_r, click_nxt, click_inc;
  logic               click_hit;
  event_t             ev;

  always_comb begin
    hold_inc  = (hold_r == CNT_MAX) ? hold_r : hold_r + CNT_W'(1);
    click_hit = (hold_r > cfg.click_min_ticks) && (hold_r < cfg.click_max_ticks);
    click_inc = (click_hit && click_r != CLICK_MAX) ? click_r + CLICK_W'(1) : click_r;
    gap_inc   = (click_inc != '0 && gap_r != CNT_MAX) ? gap_r + CNT_W'(1) : gap_r;

    ev        = EV_NONE;
    hold_nxt  = hold_r;
    gap_nxt   = gap_r;
    click_nxt = click_r;

    if (!key_level) begin
      hold_nxt = hold_inc;
      if (hold_inc > cfg.long_press_ticks) ev = EV_CONFIG;
    end else begin
      hold_nxt  = '0;
      click_nxt = click_inc;
      gap_nxt   = gap_inc;
      if (gap_inc > cfg.gap_ticks) begin
        // gap elapsed: classify pending clicks, then start over
        if (click_inc == CLICKS_TEST) begin
          ev = EV_TEST;
        end else if (click_inc == CLICKS_SINGLE) begin
          if (gas_level > cfg.alarm_level) ev = EV_SILENCE;
          else if (in_normal_mode)         ev = EV_SELFTEST;
        end
        click_nxt = '0;
        gap_nxt   = '0;
      end
    end
  end

  assign event_code = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= '0;
      gap_r   <= '0;
      click_r <= '0;
    end else if (step) begin
      hold_r  <= hold_nxt;
      gap_r   <= gap_nxt;
      click_r <= click_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/button_click_classifier_top.sv =====
// Button click classifier: one sampled key level per request, one event per request.
//
// Input channel (in_*): key_level (0 = pressed), gas_level, in_normal_mode.
// A request is taken at a clock edge with in_valid high and in_stall low.
// Output channel (out_*): out_event_code, 0 none, 1 enter config, 2 enter
// test, 3 silence alarm, 4 self test. Every request yields exactly one event.
// Pipeline: a taken request passes through the input register, then the
// result register. Throughput is one request per cycle while the result
// side is not stalled; the counters are updated in the cycle the input
// register moves into the result register.
// Stall: when out_stall holds a full result register, the input register
// keeps its request and in_stall rises while both are full.
// Reset (rst_n, synchronous, low): counters clear, both stages empty,
// thresholds return to 150/4/50/50/0.
// Thresholds are written over the cfg_* APB port at byte address 4*index;
// write them only while no request is in flight (the block does not enforce it).
// Depends on bcc_pkg, bcc_cfg_regs and bcc_core.
`default_nettype none

module button_click_classifier_top
  import bcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_key_level,
  input  wire logic [CNT_W-1:0]  in_gas_level,
  input  wire logic              in_in_normal_mode,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [EV_W-1:0]   out_event_code,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic      [DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t             cfg;
  logic             stg_vld_r;
  logic             stg_key_r;
  logic [CNT_W-1:0] stg_gas_r;
  logic             stg_normal_r;
  logic             out_vld_r;
  event_t           out_ev_r;
  event_t           core_ev;
  logic             adv;
  logic             in_take;

  // stage moves on when the result register is empty or being drained
  assign adv      = stg_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stg_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  bcc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bcc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step           (adv),
    .key_level      (stg_key_r),
    .gas_level      (stg_gas_r),
    .in_normal_mode (stg_normal_r),
    .event_code     (core_ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take)  stg_vld_r <= 1'b1;
      else if (adv) stg_vld_r <= 1'b0;
      if (adv)            out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_key_r    <= in_key_level;
      stg_gas_r    <= in_gas_level;
      stg_normal_r <= in_in_normal_mode;
    end
    if (adv) out_ev_r <= core_ev;
  end

  assign out_valid      = out_vld_r;
  assign out_event_code = out_ev_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg_vld_r && out_vld_r && out_stall))
    else $error("in_stall raised without a blocked request");

  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> stg_vld_r)
    else $error("accepted request lost from input register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced request missing from result register");

  a_config_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && core_ev == EV_CONFIG) |-> !stg_key_r)
    else $error("long-press event on a released sample");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_ev_r == EV_NONE || out_ev_r == EV_CONFIG || out_ev_r == EV_TEST
                   || out_ev_r == EV_SILENCE || out_ev_r == EV_SELFTEST))
    else $error("undefined event code on output");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for button_click_classifier_top.
// Needs bcc_pkg and the block's RTL; event predictor and scoreboard live in the tracker class.
// Drives key/gas/mode samples with random bursts, stalls the event side, checks every event.
module tb;
  import bcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50_000;

  class click_event_tracker;
    cfg_t               thr;
    logic [CNT_W-1:0]   held_ticks;
    logic [CNT_W-1:0]   released_ticks;
    logic [CLICK_W-1:0] clicks;
    event_t             pending_events[$];
    int unsigned        mismatches;

    function new();
      thr.long_press_ticks = LONG_PRESS_RST;
      thr.click_min_ticks  = CLICK_MIN_RST;
      thr.click_max_ticks  = CLICK_MAX_RST;
      thr.gap_ticks        = GAP_RST;
      thr.alarm_level      = ALARM_RST;
      held_ticks     = '0;
      released_ticks = '0;
      clicks         = '0;
      mismatches     = 0;
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void set_threshold(reg_idx_t idx, logic [CNT_W-1:0] val);
      case (idx)
        REG_LONG_PRESS: thr.long_press_ticks = val;
        REG_CLICK_MIN:  thr.click_min_ticks  = val;
        REG_CLICK_MAX:  thr.click_max_ticks  = val;
        REG_GAP:        thr.gap_ticks        = val;
        REG_ALARM:      thr.alarm_level      = val;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] threshold(reg_idx_t idx);
      case (idx)
        REG_LONG_PRESS: return thr.long_press_ticks;
        REG_CLICK_MIN:  return thr.click_min_ticks;
        REG_CLICK_MAX:  return thr.click_max_ticks;
        REG_GAP:        return thr.gap_ticks;
        default:        return thr.alarm_level;
      endcase
    endfunction

    // One sample in, one event expected out.
    function void predict_event(logic key, logic [CNT_W-1:0] gas, logic normal);
      event_t ev;
      ev = EV_NONE;
      if (!key) begin
        if (held_ticks != CNT_MAX) held_ticks++;
        if (held_ticks > thr.long_press_ticks) ev = EV_CONFIG;
      end else begin
        if (held_ticks > thr.click_min_ticks && held_ticks < thr.click_max_ticks) begin
          if (clicks != CLICK_MAX) clicks++;
        end
        if (clicks != '0 && released_ticks != CNT_MAX) released_ticks++;
        if (released_ticks > thr.gap_ticks) begin
          if (clicks == CLICKS_TEST) begin
            ev = EV_TEST;
          end else if (clicks == CLICKS_SINGLE) begin
            if (gas > thr.alarm_level) ev = EV_SILENCE;
            else if (normal) ev = EV_SELFTEST;
          end
          clicks         = '0;
          released_ticks = '0;
        end
        held_ticks = '0;
      end
      pending_events.push_back(ev);
    endfunction

    function void check_event(logic [EV_W-1:0] got);
      event_t want;
      if (pending_events.size() == 0) begin
        flag("event with no request pending", 0, got);
        return;
      end
      want = pending_events.pop_front();
      if (got !== want) flag("event_code", want, got);
    endfunction

    function int unsigned pending();
      return pending_events.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_key_level = 1'b1;
  logic [CNT_W-1:0]  in_gas_level = '0;
  logic              in_in_normal_mode = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [EV_W-1:0]   out_event_code;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  click_event_tracker sb;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  bit          fast_mode = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic [31:0] rx_cyc = '0;
  logic [1:0]  rx_mode = '0;
  int unsigned cycle_count = 0;

  button_click_classifier_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** button_click_classifier_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_event(out_event_code);
  end

  // Event-side stall pattern; a long hold-off is requested by bumping hold_req.
  always @(negedge clk) begin
    rx_cyc++;
    if (rx_cyc[5:0] == 6'd0) rx_mode = 2'($urandom_range(0, 3));
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 80;
    end
    if (!rst_n || fast_mode) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (rx_cyc[2:0] == 3'd5);
      endcase
    end
  end

  task automatic send_tick(input logic key, input logic [CNT_W-1:0] gas, input logic normal);
    int unsigned idle;
    @(negedge clk);
    in_valid          <= 1'b1;
    in_key_level      <= key;
    in_gas_level      <= gas;
    in_in_normal_mode <= normal;
    do @(posedge clk); while (in_stall);
    sb.predict_event(key, gas, normal);
    sent++;
    if (!fast_mode) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        idle = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [CNT_W-1:0] rand_gas();
    int a;
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? CNT_MAX : '0;
      1: begin
        // straddle the alarm threshold
        a = sb.thr.alarm_level;
        a = a - 1 + int'($urandom_range(0, 2));
        if (a < 0) a = 0;
        if (a > 65535) a = 65535;
        return CNT_W'(a);
      end
      default: return CNT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_same(input logic key, input logic [CNT_W-1:0] gas, input logic normal,
                           input int unsigned n);
    repeat (n) send_tick(key, gas, normal);
  endtask

  task automatic send_noisy(input logic key, input int unsigned n);
    repeat (n) send_tick(key, rand_gas(), 1'($urandom_range(0, 1)));
  endtask

  function automatic int unsigned press_len();
    int lo;
    int hi;
    lo = int'(sb.thr.click_min_ticks) + 1;
    hi = int'(sb.thr.click_max_ticks) - 1;
    if (hi >= lo && $urandom_range(0, 7) != 0) begin
      if (hi > lo + 10) hi = lo + 10;
      return $urandom_range(lo, hi);
    end
    return $urandom_range(1, 12);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned g;
    g = int'(sb.thr.gap_ticks) + 1 + $urandom_range(0, 2);
    return (g > 200) ? 200 : g;
  endfunction

  function automatic int unsigned long_len();
    int unsigned l;
    l = int'(sb.thr.long_press_ticks) + $urandom_range(1, 4);
    return (l > 60) ? 60 : l;
  endfunction

  // Mostly well-formed click groups and long presses, some raw noise.
  task automatic run_one_sequence();
    int unsigned kind;
    int unsigned nclk;
    int unsigned i;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      if ($urandom_range(0, 2) == 0) nclk = $urandom_range(1, 6);
      else nclk = ($urandom_range(0, 1) != 0) ? 1 : 3;
      for (i = 0; i < nclk; i++) begin
        send_noisy(1'b0, press_len());
        send_noisy(1'b1, (i == nclk - 1) ? gap_len() : $urandom_range(1, 2));
      end
    end else if (kind <= 7) begin
      send_noisy(1'b0, long_len());
      send_noisy(1'b1, $urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 10))
        send_tick(1'($urandom_range(0, 1)), rand_gas(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random(input int unsigned n, input bit pressure);
    int unsigned start;
    bit          pushed;
    start  = sent;
    pushed = 1'b0;
    while (sent - start < n) begin
      if (pressure && !pushed && sent - start >= n / 3) begin
        hold_req++;
        pushed = 1'b1;
      end
      run_one_sequence();
    end
  endtask

  // Wait until every request has produced its event.
  task automatic drain();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [DATA_W-1:0] rd;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[CNT_W-1:0] !== sb.threshold(idx)) begin
      sb.flag("register readback", sb.threshold(idx), rd[CNT_W-1:0]);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    // upper bits are junk, only the low half is a register
    cfg_pwdata  <= {16'($urandom_range(0, 65535)), val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_threshold(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    check_reg(idx);
  endtask

  task automatic set_thresholds(input logic [CNT_W-1:0] lp, input logic [CNT_W-1:0] mn,
                                input logic [CNT_W-1:0] mx, input logic [CNT_W-1:0] gp,
                                input logic [CNT_W-1:0] al);
    drain();
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_CLICK_MIN, mn);
    write_reg(REG_CLICK_MAX, mx);
    write_reg(REG_GAP, gp);
    write_reg(REG_ALARM, al);
  endtask

  initial begin
    int k;
    logic [CNT_W-1:0] mn;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < 5; k++) check_reg(reg_idx_t'(k));

    // directed: long press, silence, self test at level equal to alarm, three clicks
    set_thresholds(16'd2, 16'd1, 16'd4, 16'd3, 16'd100);
    send_same(1'b0, '1, 1'b1, 4);
    send_same(1'b1, '0, 1'b0, 1);
    send_same(1'b0, '0, 1'b0, 2);
    send_same(1'b1, '1, 1'b0, 4);
    send_same(1'b0, '1, 1'b1, 2);
    send_same(1'b1, 16'd100, 1'b1, 4);
    repeat (3) begin
      send_same(1'b0, 16'h5a5a, 1'b1, 2);
      send_same(1'b1, 16'ha5a5, 1'b0, 1);
    end
    send_same(1'b1, '0, 1'b1, 1);

    set_thresholds(16'd8, 16'd1, 16'd5, 16'd4, 16'($urandom_range(0, 65535)));
    run_random(80, 1'b1);
    // widest click window, shortest long press, alarm can never trip
    set_thresholds(16'd1, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF);
    run_random(60, 1'b0);
    // empty click window, gap limit of zero
    set_thresholds(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    run_random(40, 1'b0);
    mn = 16'($urandom_range(0, 6));
    set_thresholds(16'($urandom_range(1, 20)), mn, mn + 16'($urandom_range(1, 10)),
                   16'($urandom_range(1, 10)), 16'($urandom_range(0, 65535)));
    run_random(70, 1'b1);
    set_thresholds(LONG_PRESS_RST, CLICK_MIN_RST, CLICK_MAX_RST, GAP_RST, ALARM_RST);
    run_random(50, 1'b0);

    // back-to-back samples: a long press, then four clicks that are dropped
    set_thresholds(16'd12, 16'd0, 16'd2, 16'd10, 16'd0);
    fast_mode = 1'b1;
    send_noisy(1'b0, 20);
    send_noisy(1'b1, 1);
    repeat (4) begin
      send_noisy(1'b0, 1);
      send_noisy(1'b1, 1);
    end
    send_noisy(1'b1, 12);
    drain();
    fast_mode = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** button_click_classifier_top: PASSED **");
    end else begin
      $display("** button_click_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule
